// ===== rtl/ede_pkg.sv =====
package ede_pkg;

  // Command codes carried on the command port
  localparam logic [1:0] CmdFirst   = 2'd0;
  localparam logic [1:0] CmdSecond  = 2'd1;
  localparam logic [1:0] CmdCompute = 2'd2;

  localparam int unsigned DistW = 7;
  localparam logic [DistW-1:0] DistMax = 7'd127;

  // Controller to datapath
  typedef struct packed {
    logic append_a;   // append symbol to first string
    logic append_b;   // append symbol to second string
    logic init_clr;   // reset column and row counters
    logic init_wr;    // write one entry of the initial row
    logic row_rd;     // fetch row entry zero and first string byte
    logic row_ld;     // latch row byte and diagonal, write row entry zero
    logic cell_rd;    // fetch up entry and second string byte
    logic cell_wr;    // evaluate one cell and write it back
    logic row_next;   // advance to next row
    logic done_clr;   // clear lengths and overflow
  } ede_cmd_t;

  // Datapath to controller
  typedef struct packed {
    logic j_at_lb;
    logic i_at_la;
    logic la_zero;
    logic lb_zero;
  } ede_sts_t;

endpackage

// ===== rtl/ede_dpath.sv =====
module ede_dpath #(
  parameter int unsigned MAX_LEN = 64
) (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  ede_pkg::ede_cmd_t          cmd_i,
  input  logic [7:0]                 symbol_i,
  output ede_pkg::ede_sts_t          sts_o,
  output logic [ede_pkg::DistW-1:0]  distance_o,
  output logic                       overflow_o
);

  localparam int unsigned LW = $clog2(MAX_LEN + 1);
  localparam int unsigned AW = (MAX_LEN > 1) ? $clog2(MAX_LEN) : 1;

  logic [7:0]    first_mem  [MAX_LEN];
  logic [7:0]    second_mem [MAX_LEN];
  logic [LW-1:0] row_mem    [MAX_LEN + 1];

  logic [LW-1:0] len_a_q, len_b_q;
  logic          ovf_q;
  logic [LW-1:0] i_q, j_q;
  logic [LW-1:0] diag_q, left_q, last_q;
  logic [7:0]    a_q;
  logic [7:0]    fs_rd_q, ss_rd_q;
  logic [LW-1:0] row_rd_q;

  logic [AW-1:0] i_m1, j_m1;
  logic [LW-1:0] row_raddr, row_waddr, row_wdata;
  logic          row_we;
  logic [LW-1:0] min_du, min3, cell_val;

  assign i_m1 = AW'(i_q - LW'(1));
  assign j_m1 = AW'(j_q - LW'(1));

  // Cell evaluation: match takes diagonal, else one plus smallest neighbor
  assign min_du   = (diag_q <= row_rd_q) ? diag_q : row_rd_q;
  assign min3     = (min_du <= left_q) ? min_du : left_q;
  assign cell_val = (a_q == ss_rd_q) ? diag_q : min3 + LW'(1);

  assign row_raddr = cmd_i.cell_rd ? j_q : '0;
  assign row_we    = cmd_i.init_wr | cmd_i.row_ld | cmd_i.cell_wr;

  always_comb begin
    row_waddr = j_q;
    row_wdata = cell_val;
    if (cmd_i.init_wr) begin
      row_wdata = j_q;
    end else if (cmd_i.row_ld) begin
      row_waddr = '0;
      row_wdata = i_q;
    end
  end

  // String stores
  always_ff @(posedge clk_i) begin
    if (cmd_i.append_a && (32'(len_a_q) < MAX_LEN)) begin
      first_mem[len_a_q[AW-1:0]] <= symbol_i;
    end
    if (cmd_i.append_b && (32'(len_b_q) < MAX_LEN)) begin
      second_mem[len_b_q[AW-1:0]] <= symbol_i;
    end
    if (cmd_i.row_rd) begin
      fs_rd_q <= first_mem[i_m1];
    end
    ss_rd_q <= second_mem[j_m1];
  end

  // Single row store, read returns the old entry
  always_ff @(posedge clk_i) begin
    row_rd_q <= row_mem[row_raddr];
    if (row_we) begin
      row_mem[row_waddr] <= row_wdata;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      len_a_q <= '0;
      len_b_q <= '0;
      ovf_q   <= 1'b0;
      i_q     <= '0;
      j_q     <= '0;
    end else begin
      if (cmd_i.append_a) begin
        if (32'(len_a_q) < MAX_LEN) len_a_q <= len_a_q + LW'(1);
        else                        ovf_q   <= 1'b1;
      end
      if (cmd_i.append_b) begin
        if (32'(len_b_q) < MAX_LEN) len_b_q <= len_b_q + LW'(1);
        else                        ovf_q   <= 1'b1;
      end
      if (cmd_i.init_clr) begin
        j_q <= '0;
        i_q <= LW'(1);
      end
      if (cmd_i.init_wr || cmd_i.cell_wr) j_q <= j_q + LW'(1);
      if (cmd_i.row_ld)   j_q <= LW'(1);
      if (cmd_i.row_next) i_q <= i_q + LW'(1);
      if (cmd_i.done_clr) begin
        len_a_q <= '0;
        len_b_q <= '0;
        ovf_q   <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.init_wr) begin
      last_q <= j_q;
    end
    if (cmd_i.row_ld) begin
      a_q    <= fs_rd_q;
      diag_q <= row_rd_q;
      left_q <= i_q;
      last_q <= i_q;
    end
    if (cmd_i.cell_wr) begin
      diag_q <= row_rd_q;
      left_q <= cell_val;
      last_q <= cell_val;
    end
  end

  assign sts_o.j_at_lb = (j_q == len_b_q);
  assign sts_o.i_at_la = (i_q == len_a_q);
  assign sts_o.la_zero = (len_a_q == '0);
  assign sts_o.lb_zero = (len_b_q == '0);

  assign distance_o = (32'(last_q) > 32'(ede_pkg::DistMax)) ? ede_pkg::DistMax
                                                           : ede_pkg::DistW'(last_q);
  assign overflow_o = ovf_q;

endmodule

// ===== rtl/ede_ctrl.sv =====
module ede_ctrl (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               start,
  input  logic [1:0]         command_i,
  input  ede_pkg::ede_sts_t  sts_i,
  output ede_pkg::ede_cmd_t  cmd_o,
  output logic               busy,
  output logic               done_o
);

  localparam logic [2:0] StIdle     = 3'd0;
  localparam logic [2:0] StInit     = 3'd1;
  localparam logic [2:0] StRowStart = 3'd2;
  localparam logic [2:0] StRowLoad  = 3'd3;
  localparam logic [2:0] StCellRd   = 3'd4;
  localparam logic [2:0] StCellWr   = 3'd5;
  localparam logic [2:0] StDone     = 3'd6;

  logic [2:0] state_q, state_d;

  always_comb begin
    state_d = state_q;
    cmd_o   = '0;
    unique case (state_q)
      StIdle: begin
        if (start) begin
          unique case (command_i)
            ede_pkg::CmdFirst:   cmd_o.append_a = 1'b1;
            ede_pkg::CmdSecond:  cmd_o.append_b = 1'b1;
            ede_pkg::CmdCompute: begin
              cmd_o.init_clr = 1'b1;
              state_d        = StInit;
            end
            default: ;
          endcase
        end
      end
      StInit: begin
        cmd_o.init_wr = 1'b1;
        if (sts_i.j_at_lb) state_d = sts_i.la_zero ? StDone : StRowStart;
      end
      StRowStart: begin
        cmd_o.row_rd = 1'b1;
        state_d      = StRowLoad;
      end
      StRowLoad: begin
        cmd_o.row_ld = 1'b1;
        if (!sts_i.lb_zero) begin
          state_d = StCellRd;
        end else if (sts_i.i_at_la) begin
          state_d = StDone;
        end else begin
          cmd_o.row_next = 1'b1;
          state_d        = StRowStart;
        end
      end
      StCellRd: begin
        cmd_o.cell_rd = 1'b1;
        state_d       = StCellWr;
      end
      StCellWr: begin
        cmd_o.cell_wr = 1'b1;
        if (!sts_i.j_at_lb) begin
          state_d = StCellRd;
        end else if (sts_i.i_at_la) begin
          state_d = StDone;
        end else begin
          cmd_o.row_next = 1'b1;
          state_d        = StRowStart;
        end
      end
      StDone: begin
        cmd_o.done_clr = 1'b1;
        state_d        = StIdle;
      end
      default: state_d = StIdle;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= StIdle;
    end else begin
      state_q <= state_d;
    end
  end

  assign busy   = (state_q != StIdle);
  assign done_o = (state_q == StDone);

endmodule

// ===== rtl/edit_distance_engine_unit.sv =====
// Channel   Direction  Handshake              Payload
// item      in         start & !busy          command_i[1:0], symbol_i[7:0]
// result    out        done_o (one cycle)     distance_o[6:0], overflow_o
//
// Append commands complete in the accept cycle; busy stays low.
// Compute raises busy after the accept cycle and holds it through the table walk.
// Each table cell has a read state and a write state because the row store read is
// registered (fetch up entry and second string byte, then evaluate and write back).
// The result strobe sits in the last busy cycle; lengths and overflow clear there.
// Reset clears the controller, both lengths and the overflow flag; the string
// and row stores hold no reset and need no clearing pass.
// The receiver cannot stall: done_o carries each result for one cycle only.
module edit_distance_engine_unit #(
  parameter int unsigned MAX_LEN = 64
) (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       start,
  output logic                       busy,
  input  logic [1:0]                 command_i,
  input  logic [7:0]                 symbol_i,
  output logic                       done_o,
  output logic [ede_pkg::DistW-1:0]  distance_o,
  output logic                       overflow_o
);

  ede_pkg::ede_cmd_t cmd;
  ede_pkg::ede_sts_t sts;

  // Sequence appends and the table walk
  ede_ctrl u_ctrl (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .start     (start),
    .command_i (command_i),
    .sts_i     (sts),
    .cmd_o     (cmd),
    .busy      (busy),
    .done_o    (done_o)
  );

  // Hold the strings, the single row and the cell arithmetic
  ede_dpath #(
    .MAX_LEN (MAX_LEN)
  ) u_dpath (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cmd_i      (cmd),
    .symbol_i   (symbol_i),
    .sts_o      (sts),
    .distance_o (distance_o),
    .overflow_o (overflow_o)
  );

endmodule
